// ----- sv/jsm_pkg.sv -----
// Shared types and constants of the joystick servo mixer.
`default_nettype none

package jsm_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 15;
  localparam int unsigned IN_TDATA_W = 96;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef enum logic [CFG_AW-1:0] {
    CFG_DZ_LEFT      = 3'd0,
    CFG_DZ_RIGHT     = 3'd1,
    CFG_WHEEL_CENTER = 3'd2,
    CFG_WHEEL_SPAN   = 3'd3,
    CFG_PAN_CENTER   = 3'd4,
    CFG_PAN_SPAN     = 3'd5,
    CFG_TILT_CENTER  = 3'd6,
    CFG_TILT_SPAN    = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0] dz_left;
    logic [14:0] dz_right;
    logic [11:0] wheel_center;
    logic [9:0]  wheel_span;
    logic [11:0] pan_center;
    logic [9:0]  pan_span;
    logic [11:0] tilt_center;
    logic [9:0]  tilt_span;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] left_trigger;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [15:0] right_trigger;
  } sample_t;

  typedef struct packed {
    logic [12:0] front_wheel;
    logic [12:0] rear_wheel;
    logic [12:0] pan_pulse;
    logic [12:0] tilt_pulse;
    logic [9:0]  drive_power;
  } res_t;

  localparam logic [14:0] DZ_LEFT_RST  = 15'd5000;
  localparam logic [14:0] DZ_RIGHT_RST = 15'd10000;
  localparam logic [11:0] CENTER_RST   = 12'd1501;
  localparam logic [9:0]  SPAN_RST     = 10'd500;
  localparam logic [12:0] PULSE_RST    = 13'd1501;
  localparam logic [9:0]  POWER_RST    = 10'd0;

  localparam int unsigned MUL_AW = 45;
  localparam int unsigned MUL_BW = 20;
  localparam int unsigned MUL_PW = MUL_AW + MUL_BW;

  // cut numerator is 655340 - 7*(lt + 32767), boost numerator 65534 + rt + 32767
  localparam logic [19:0] CUT_BASE    = 20'd425971;
  localparam logic [19:0] CUT_STEP    = 20'd7;
  localparam logic [17:0] BOOST_BASE  = 18'd98301;
  localparam logic [19:0] POWER_SCALE = 20'd175;

  localparam logic [44:0] DIV_STEER = 45'd655340;
  localparam logic [44:0] DIV_P     = 45'd32767;
  localparam logic [44:0] DIV_PW    = 45'd42947051560;
  localparam logic [44:0] DIV_MAP   = 45'd32762;

  localparam int unsigned S_STEER = 35;
  localparam int unsigned S_P     = 23;
  localparam int unsigned S_PW    = 44;
  localparam int unsigned S_MAP   = 26;

  localparam logic [19:0] M_STEER = 20'((64'd1 << S_STEER) / 64'd655340);
  localparam logic [19:0] M_P     = 20'((64'd1 << S_P) / 64'd32767);
  localparam logic [19:0] M_PW    = 20'((64'd1 << S_PW) / 64'd42947051560);
  localparam logic [19:0] M_MAP   = 20'((64'd1 << S_MAP) / 64'd32762);

  localparam logic signed [13:0] PULSE_MAX = 14'sd4095;
  localparam logic signed [13:0] PULSE_MIN = -14'sd1024;
  localparam logic [8:0]         POWER_LIM = 9'd350;

endpackage

`default_nettype wire

// ----- sv/jsm_cfg.sv -----
// Configuration register bank of the joystick servo mixer.
`default_nettype none

module jsm_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [jsm_pkg::CFG_AW-1:0]  addr_i,
  input  logic [jsm_pkg::CFG_DW-1:0]  wdata_i,
  output jsm_pkg::cfg_t               cfg_o
);
  import jsm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dz_left      <= DZ_LEFT_RST;
      cfg_q.dz_right     <= DZ_RIGHT_RST;
      cfg_q.wheel_center <= CENTER_RST;
      cfg_q.wheel_span   <= SPAN_RST;
      cfg_q.pan_center   <= CENTER_RST;
      cfg_q.pan_span     <= SPAN_RST;
      cfg_q.tilt_center  <= CENTER_RST;
      cfg_q.tilt_span    <= SPAN_RST;
    end else if (we_i) begin
      unique case (cfg_idx_e'(addr_i))
        CFG_DZ_LEFT:      cfg_q.dz_left      <= wdata_i;
        CFG_DZ_RIGHT:     cfg_q.dz_right     <= wdata_i;
        CFG_WHEEL_CENTER: cfg_q.wheel_center <= wdata_i[11:0];
        CFG_WHEEL_SPAN:   cfg_q.wheel_span   <= wdata_i[9:0];
        CFG_PAN_CENTER:   cfg_q.pan_center   <= wdata_i[11:0];
        CFG_PAN_SPAN:     cfg_q.pan_span     <= wdata_i[9:0];
        CFG_TILT_CENTER:  cfg_q.tilt_center  <= wdata_i[11:0];
        CFG_TILT_SPAN:    cfg_q.tilt_span    <= wdata_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- sv/jsm_mul.sv -----
// Shared registered multiplier of the joystick servo mixer.
`default_nettype none

module jsm_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [jsm_pkg::MUL_AW-1:0]  a_i,
  input  logic [jsm_pkg::MUL_BW-1:0]  b_i,
  output logic [jsm_pkg::MUL_PW-1:0]  p_o
);
  import jsm_pkg::*;

  logic [MUL_PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_PW'(a_i) * MUL_PW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ----- sv/jsm_core.sv -----
// Sequencer and datapath of the mixer around the shared multiplier.
`default_nettype none

module jsm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  jsm_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  jsm_pkg::sample_t  in_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output jsm_pkg::res_t     res_o
);
  import jsm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RECIP,
    ST_BACK,
    ST_FIX,
    ST_CMP,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    J_STEER,
    J_PWR_Y,
    J_PWR_B,
    J_PWR_C,
    J_WHEEL,
    J_PAN,
    J_TILT
  } job_e;

  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } axis_t;

  function automatic axis_t dead_zone(logic [15:0] v, logic [14:0] dz);
    logic signed [16:0] vs;
    logic signed [16:0] ds;
    logic signed [16:0] r;
    axis_t              a;
    vs = $signed({v[15], v});
    ds = $signed({2'b00, dz});
    if (vs > ds) begin
      r = vs - ds;
    end else if (vs < -ds) begin
      r = vs + ds;
    end else begin
      r = '0;
    end
    a.neg = r[16];
    a.mag = 16'(r[16] ? -r : r);
    return a;
  endfunction

  function automatic logic [12:0] sat_pulse(logic signed [13:0] v);
    logic [12:0] s;
    if (v > PULSE_MAX) begin
      s = 13'(PULSE_MAX);
    end else if (v < PULSE_MIN) begin
      s = 13'(PULSE_MIN);
    end else begin
      s = 13'(v);
    end
    return s;
  endfunction

  state_e state_q, state_d;
  job_e   job_q, job_d;

  axis_t       lx_q, ly_q, rx_q, ry_q;
  logic [19:0] cut_q;
  logic [17:0] bst_q;
  logic [44:0] x_q;
  logic [19:0] q0_q;
  logic [15:0] steer_q;
  logic [7:0]  pmag_q;
  logic [8:0]  pw_q;
  logic [9:0]  tw_q, tp_q, tt_q;

  logic [12:0] front_q, rear_q, pan_q, tilt_q;
  logic [9:0]  power_q;

  logic              mul_en;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;

  logic [44:0] div_d;
  logic [19:0] div_m;
  logic [19:0] q0;
  logic [44:0] fix_r;
  logic [19:0] fix_q;

  logic signed [13:0] wc14, pc14, tc14, tw14, tp14, tt14;
  logic signed [13:0] front_s, rear_s, pan_s, tilt_s;
  logic [9:0]  pw10;
  logic [12:0] front_n, rear_n, pan_n, tilt_n;
  logic [9:0]  power_n;
  logic        chg;
  logic        accept;

  jsm_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    div_d = DIV_MAP;
    div_m = M_MAP;
    q0    = 20'(mul_p >> S_MAP);
    unique case (job_q)
      J_STEER: begin
        div_d = DIV_STEER;
        div_m = M_STEER;
        q0    = 20'(mul_p >> S_STEER);
      end
      J_PWR_Y, J_PWR_B: begin
        div_d = DIV_P;
        div_m = M_P;
        q0    = 20'(mul_p >> S_P);
      end
      J_PWR_C: begin
        div_d = DIV_PW;
        div_m = M_PW;
        q0    = 20'(mul_p >> S_PW);
      end
      J_WHEEL, J_PAN, J_TILT: begin
        div_d = DIV_MAP;
        div_m = M_MAP;
        q0    = 20'(mul_p >> S_MAP);
      end
      default: ;
    endcase
  end

  assign fix_r = x_q - mul_p[44:0];
  assign fix_q = q0_q + 20'(fix_r >= div_d);

  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      ST_MUL: begin
        mul_en = 1'b1;
        unique case (job_q)
          J_STEER: begin
            mul_a = MUL_AW'(rx_q.mag);
            mul_b = cut_q;
          end
          J_PWR_Y: begin
            mul_a = MUL_AW'(ly_q.mag);
            mul_b = POWER_SCALE;
          end
          J_PWR_B: begin
            mul_a = MUL_AW'(pmag_q);
            mul_b = MUL_BW'(bst_q);
          end
          J_PWR_C: begin
            mul_a = mul_p[44:0];
            mul_b = cut_q;
          end
          J_WHEEL: begin
            mul_a = MUL_AW'(steer_q);
            mul_b = MUL_BW'(cfg_i.wheel_span);
          end
          J_PAN: begin
            mul_a = MUL_AW'(ry_q.mag);
            mul_b = MUL_BW'(cfg_i.pan_span);
          end
          J_TILT: begin
            mul_a = MUL_AW'(lx_q.mag);
            mul_b = MUL_BW'(cfg_i.tilt_span);
          end
          default: ;
        endcase
      end
      ST_RECIP: begin
        mul_en = 1'b1;
        mul_a  = mul_p[44:0];
        mul_b  = div_m;
      end
      ST_BACK: begin
        mul_en = 1'b1;
        mul_a  = div_d;
        mul_b  = q0;
      end
      default: ;
    endcase
  end

  always_comb begin
    wc14 = $signed({2'b00, cfg_i.wheel_center});
    pc14 = $signed({2'b00, cfg_i.pan_center});
    tc14 = $signed({2'b00, cfg_i.tilt_center});
    tw14 = $signed({4'b0000, tw_q});
    tp14 = $signed({4'b0000, tp_q});
    tt14 = $signed({4'b0000, tt_q});
    front_s = rx_q.neg ? wc14 - tw14 : wc14 + tw14;
    rear_s  = rx_q.neg ? wc14 + tw14 : wc14 - tw14;
    pan_s   = ry_q.neg ? pc14 - tp14 : pc14 + tp14;
    tilt_s  = lx_q.neg ? tc14 - tt14 : tc14 + tt14;
    front_n = sat_pulse(front_s);
    rear_n  = sat_pulse(rear_s);
    pan_n   = sat_pulse(pan_s);
    tilt_n  = sat_pulse(tilt_s);
    pw10    = (pw_q > POWER_LIM) ? {1'b0, POWER_LIM} : {1'b0, pw_q};
    power_n = ly_q.neg ? pw10 : 10'(-pw10);
    chg = (front_n != front_q) || (rear_n != rear_q) || (pan_n != pan_q) ||
          (tilt_n != tilt_q) || (power_n != power_q);
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = in_i.op ? ST_OUT : ST_MUL;
          job_d   = J_STEER;
        end
      end
      ST_MUL: begin
        if (job_q == J_PWR_B) begin
          job_d = J_PWR_C;
        end else begin
          state_d = ST_RECIP;
        end
      end
      ST_RECIP: state_d = ST_BACK;
      ST_BACK:  state_d = ST_FIX;
      ST_FIX: begin
        state_d = ST_MUL;
        unique case (job_q)
          J_STEER: job_d = J_PWR_Y;
          J_PWR_Y: job_d = J_PWR_B;
          J_PWR_B: job_d = J_PWR_C;
          J_PWR_C: job_d = J_WHEEL;
          J_WHEEL: job_d = J_PAN;
          J_PAN:   job_d = J_TILT;
          J_TILT:  state_d = ST_CMP;
          default: state_d = ST_IDLE;
        endcase
      end
      ST_CMP: state_d = chg ? ST_OUT : ST_IDLE;
      ST_OUT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      job_q   <= J_STEER;
      front_q <= PULSE_RST;
      rear_q  <= PULSE_RST;
      pan_q   <= PULSE_RST;
      tilt_q  <= PULSE_RST;
      power_q <= POWER_RST;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      if (state_q == ST_CMP && chg) begin
        front_q <= front_n;
        rear_q  <= rear_n;
        pan_q   <= pan_n;
        tilt_q  <= tilt_n;
        power_q <= power_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !in_i.op) begin
      lx_q  <= dead_zone(in_i.left_x, cfg_i.dz_left);
      ly_q  <= dead_zone(in_i.left_y, cfg_i.dz_left);
      rx_q  <= dead_zone(in_i.right_x, cfg_i.dz_right);
      ry_q  <= dead_zone(in_i.right_y, cfg_i.dz_right);
      cut_q <= CUT_BASE - ({{4{in_i.left_trigger[15]}}, in_i.left_trigger} * CUT_STEP);
      bst_q <= BOOST_BASE + {{2{in_i.right_trigger[15]}}, in_i.right_trigger};
    end
    if (state_q == ST_RECIP) begin
      x_q <= mul_p[44:0];
    end
    if (state_q == ST_BACK) begin
      q0_q <= q0;
    end
    if (state_q == ST_FIX) begin
      unique case (job_q)
        J_STEER: steer_q <= fix_q[15:0];
        J_PWR_Y: pmag_q  <= fix_q[7:0];
        J_PWR_C: pw_q    <= fix_q[8:0];
        J_WHEEL: tw_q    <= fix_q[9:0];
        J_PAN:   tp_q    <= fix_q[9:0];
        J_TILT:  tt_q    <= fix_q[9:0];
        default: ;
      endcase
    end
  end

  assign res_valid_o       = (state_q == ST_OUT) && out_free_i;
  assign res_o.front_wheel = front_q;
  assign res_o.rear_wheel  = rear_q;
  assign res_o.pan_pulse   = pan_q;
  assign res_o.tilt_pulse  = tilt_q;
  assign res_o.drive_power = power_q;

`ifndef SYNTH
  a_fix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIX) |-> (fix_r < (div_d << 1)))
    else $error("reciprocal estimate off by more than one");

  a_resend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_i.op) |=> (state_q == ST_OUT))
    else $error("resend word did not go straight to output");

  a_power_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (pw_q <= POWER_LIM))
    else $error("power quotient beyond limit");

  a_boost_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && job_q == J_PWR_B) |=> (state_q == ST_MUL && job_q == J_PWR_C))
    else $error("boost product not followed by cut product");
`endif

endmodule

`default_nettype wire

// ----- sv/joystick_servo_mixer.sv -----
// Top level of the joystick servo mixer: stream ports, output register, config.
// Sequence: a sample word (op 0) runs six constant divides, each a product,
// reciprocal, back-multiply and fix step, plus one extra product, a compare and,
// when the result changed, an output state; a resend word (op 1) goes straight to
// the output state. A new word is taken only when the previous one is done, and
// the output state waits while the output register is full.
// Reset: asynchronous, active low; config returns to defaults, last result to
// 1501/1501/1501/1501/0, output empty. No clearing pass.
`default_nettype none

module joystick_servo_mixer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [jsm_pkg::CFG_AW-1:0]        cfg_addr_i,
  input  logic [jsm_pkg::CFG_DW-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // left_x, left_y, left_trigger, right_x, right_y, right_trigger (16 bits each)
  input  logic [jsm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // op
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // front_wheel, rear_wheel, pan_pulse, tilt_pulse (13 bits each), drive_power (10), pad
  output logic [jsm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import jsm_pkg::*;

  cfg_t    cfg;
  sample_t smp;
  res_t    res;
  logic    res_valid;
  logic    out_free;

  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  assign smp.op            = s_axis_tuser;
  assign smp.left_x        = s_axis_tdata[15:0];
  assign smp.left_y        = s_axis_tdata[31:16];
  assign smp.left_trigger  = s_axis_tdata[47:32];
  assign smp.right_x       = s_axis_tdata[63:48];
  assign smp.right_y       = s_axis_tdata[79:64];
  assign smp.right_trigger = s_axis_tdata[95:80];

  jsm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  jsm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_i        (smp),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_data_q <= {2'b00, res.drive_power, res.tilt_pulse, res.pan_pulse,
                   res.rear_wheel, res.front_wheel};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// ----- test/joystick_servo_mixer_tb.sv -----
// Self-checking testbench for the joystick servo mixer with a built-in result predictor.
`timescale 1ns / 100ps

module joystick_servo_mixer_tb;
  import jsm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;
  localparam int HOLD_CYCLES = 600;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr_i    = '0;
  logic [CFG_DW-1:0]      cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  sample_t pending_words[$];
  res_t    due_results[$];
  sample_t prev_sample;
  bit      have_prev = 1'b0;

  cfg_t cfg_now = {DZ_LEFT_RST, DZ_RIGHT_RST, CENTER_RST, SPAN_RST,
                   CENTER_RST, SPAN_RST, CENTER_RST, SPAN_RST};
  res_t last_sent = {PULSE_RST, PULSE_RST, PULSE_RST, PULSE_RST, POWER_RST};

  int errors     = 0;
  int gap_pct    = 37;
  int stall_pct  = 37;
  int cycle_cnt  = 0;
  int hold_left  = 0;
  bit hold_armed = 1'b0;
  bit hold_done  = 1'b0;

  joystick_servo_mixer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint dz_shift(logic [15:0] v, logic [14:0] dz);
    longint a;
    longint d;
    a = $signed(v);
    d = dz;
    if (a > d) return a - d;
    if (a < -d) return a + d;
    return 0;
  endfunction

  function automatic logic [12:0] servo_pulse(logic [11:0] c, logic [9:0] s, longint j);
    longint ce;
    longint sp;
    longint v;
    ce = c;
    sp = s;
    v = (j * sp) / 32762 + ce;
    if (v < -1024) v = -1024;
    if (v > 4095) v = 4095;
    return v[12:0];
  endfunction

  task automatic predict_word(sample_t w);
    longint lx, ly, rx, ry, lt, rt, cutn, steer, p, pw;
    res_t nr;
    if (w.op) begin
      due_results.push_back(last_sent);
      return;
    end
    lx = dz_shift(w.left_x, cfg_now.dz_left);
    ly = dz_shift(w.left_y, cfg_now.dz_left);
    rx = dz_shift(w.right_x, cfg_now.dz_right);
    ry = dz_shift(w.right_y, cfg_now.dz_right);
    lt = $signed(w.left_trigger);
    rt = $signed(w.right_trigger);
    cutn = 655340 - 7 * (lt + 32767);
    steer = (rx * cutn) / 655340;
    p = (ly * 175) / 32767;
    pw = -((p * (65534 + rt + 32767) * cutn) / (longint'(65534) * 655340));
    if (pw < -350) pw = -350;
    if (pw > 350) pw = 350;
    nr.front_wheel = servo_pulse(cfg_now.wheel_center, cfg_now.wheel_span, steer);
    nr.rear_wheel  = servo_pulse(cfg_now.wheel_center, cfg_now.wheel_span, -steer);
    nr.pan_pulse   = servo_pulse(cfg_now.pan_center, cfg_now.pan_span, ry);
    nr.tilt_pulse  = servo_pulse(cfg_now.tilt_center, cfg_now.tilt_span, lx);
    nr.drive_power = pw[9:0];
    if (nr != last_sent) begin
      last_sent = nr;
      due_results.push_back(nr);
    end
  endtask

  task automatic note_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  // drive the sample stream
  always @(posedge clk_i) begin : drive
    sample_t w;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        w.op = s_axis_tuser;
        {w.right_trigger, w.right_y, w.right_x, w.left_trigger, w.left_y, w.left_x} =
          s_axis_tdata;
        predict_word(w);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
          w = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= w.op;
          s_axis_tdata  <= {w.right_trigger, w.right_y, w.right_x,
                            w.left_trigger, w.left_y, w.left_x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // hold off the receiver once, else stall at random
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left     <= HOLD_CYCLES;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : watch
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.front_wheel = m_axis_tdata[12:0];
      got.rear_wheel  = m_axis_tdata[25:13];
      got.pan_pulse   = m_axis_tdata[38:26];
      got.tilt_pulse  = m_axis_tdata[51:39];
      got.drive_power = m_axis_tdata[61:52];
      if (due_results.size() == 0) begin
        note_mismatch("unexpected word, front_wheel", got.front_wheel, 0);
      end else begin
        want = due_results.pop_front();
        if (got.front_wheel != want.front_wheel)
          note_mismatch("front_wheel", got.front_wheel, want.front_wheel);
        if (got.rear_wheel != want.rear_wheel)
          note_mismatch("rear_wheel", got.rear_wheel, want.rear_wheel);
        if (got.pan_pulse != want.pan_pulse)
          note_mismatch("pan_pulse", got.pan_pulse, want.pan_pulse);
        if (got.tilt_pulse != want.tilt_pulse)
          note_mismatch("tilt_pulse", got.tilt_pulse, want.tilt_pulse);
        if (got.drive_power != want.drive_power)
          note_mismatch("drive_power", got.drive_power, want.drive_power);
        if (m_axis_tdata[63:62] != 2'b00)
          note_mismatch("pad", m_axis_tdata[63:62], 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic add_word(bit op, int lx, int ly, int lt, int rx, int ry, int rt);
    sample_t w;
    w.op            = op;
    w.left_x        = lx[15:0];
    w.left_y        = ly[15:0];
    w.left_trigger  = lt[15:0];
    w.right_x       = rx[15:0];
    w.right_y       = ry[15:0];
    w.right_trigger = rt[15:0];
    pending_words.push_back(w);
  endtask

  function automatic logic [15:0] pick_axis(logic [14:0] dz);
    int d;
    d = dz;
    case ($urandom_range(7))
      0: return d[15:0];
      1: return 16'(-d);
      2: return 16'(d + 1);
      3: return 16'(-(d + 1));
      4: return $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_random(int n, int resend_pct);
    sample_t w;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < resend_pct) begin
        w.op            = 1'b1;
        w.left_x        = 16'($urandom);
        w.left_y        = 16'($urandom);
        w.left_trigger  = 16'($urandom);
        w.right_x       = 16'($urandom);
        w.right_y       = 16'($urandom);
        w.right_trigger = 16'($urandom);
      end else if (k < resend_pct + 10 && have_prev) begin
        w = prev_sample;
      end else begin
        w.op            = 1'b0;
        w.left_x        = pick_axis(cfg_now.dz_left);
        w.left_y        = pick_axis(cfg_now.dz_left);
        w.left_trigger  = pick_axis(15'd0);
        w.right_x       = pick_axis(cfg_now.dz_right);
        w.right_y       = pick_axis(cfg_now.dz_right);
        w.right_trigger = pick_axis(15'd0);
      end
      if (!w.op) begin
        prev_sample = w;
        have_prev   = 1'b1;
      end
      pending_words.push_back(w);
    end
  endtask

  task automatic set_reg(cfg_idx_e idx, int val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val[14:0];
    case (idx)
      CFG_DZ_LEFT:      cfg_now.dz_left      = val[14:0];
      CFG_DZ_RIGHT:     cfg_now.dz_right     = val[14:0];
      CFG_WHEEL_CENTER: cfg_now.wheel_center = val[11:0];
      CFG_WHEEL_SPAN:   cfg_now.wheel_span   = val[9:0];
      CFG_PAN_CENTER:   cfg_now.pan_center   = val[11:0];
      CFG_PAN_SPAN:     cfg_now.pan_span     = val[9:0];
      CFG_TILT_CENTER:  cfg_now.tilt_center  = val[11:0];
      CFG_TILT_SPAN:    cfg_now.tilt_span    = val[9:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(int dzl, int dzr, int wc, int ws, int pc, int ps, int tc, int ts);
    set_reg(CFG_DZ_LEFT, dzl);
    set_reg(CFG_DZ_RIGHT, dzr);
    set_reg(CFG_WHEEL_CENTER, wc);
    set_reg(CFG_WHEEL_SPAN, ws);
    set_reg(CFG_PAN_CENTER, pc);
    set_reg(CFG_PAN_SPAN, ps);
    set_reg(CFG_TILT_CENTER, tc);
    set_reg(CFG_TILT_SPAN, ts);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // wait for the block to drain, then let any silent sample finish
  task automatic settle();
    while (pending_words.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_word(0, 0, 0, 0, 0, 0, 0);
    add_word(1, -1, -1, -1, -1, -1, -1);
    add_word(0, 32767, 32767, 32767, 32767, 32767, 32767);
    add_word(0, -32768, -32768, -32768, -32768, -32768, -32768);
    add_word(0, -32768, -32768, -32768, -32768, -32768, -32768);
    add_word(0, 5000, 0, 0, 0, 0, 0);
    add_word(0, -5000, -5000, 0, 0, 0, 0);
    add_word(0, 5001, -5001, 0, 10001, -10001, 0);
    add_word(0, 0, 0, 0, 10000, -10000, 0);
    add_word(0, 0, 32767, -32768, 0, 0, 32767);
    add_word(0, 0, -32768, 32767, 32767, 0, -32768);
    add_word(0, 0, 32767, 32767, -32768, 0, 32767);
    add_word(1, 0, 0, 0, 0, 0, 0);
    add_word(1, 21845, 21845, 21845, 21845, 21845, 21845);
    add_word(0, 12345, -23456, 1000, -30000, 20000, -5);
    add_word(0, 12345, -23456, 1000, -30000, 20000, -5);
    settle();

    load_regs($urandom_range(32767), $urandom_range(32767), $urandom_range(2500, 500),
              $urandom_range(1000), $urandom_range(2500, 500), $urandom_range(1000),
              $urandom_range(2500, 500), $urandom_range(1000));
    add_random(300, 15);
    settle();

    gap_pct   = 0;
    stall_pct = 0;
    load_regs(0, 0, 500, 1000, 2500, 1000, 500, 0);
    add_random(200, 15);
    settle();

    gap_pct   = 37;
    stall_pct = 37;
    load_regs(32767, 32767, 2500, 0, 500, 0, 2500, 1000);
    add_random(60, 15);
    settle();

    // drive the pulses into saturation
    load_regs(0, 0, 4095, 1023, 4095, 1023, 0, 1023);
    add_random(80, 15);
    settle();

    load_regs(5000, 10000, 1501, 500, 1501, 500, 1501, 500);
    hold_armed = 1'b1;
    add_random(300, 60);
    settle();

    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/jsm_pkg.sv
sv/jsm_cfg.sv
sv/jsm_mul.sv
sv/jsm_core.sv
sv/joystick_servo_mixer.sv
test/joystick_servo_mixer_tb.sv
